// File: rtl/core/wps_pkg.sv
// shared constants, types and byte-class function for the wildcard pattern search
package wps_pkg;

    localparam int PATTERN_MAX   = 16;
    localparam int POSITION_BITS = 24;
    localparam int LEN_BITS      = $clog2(PATTERN_MAX + 1);
    localparam int CFG_LEN_W     = 5;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = ((1 + POSITION_BITS + 7) / 8) * 8;

    localparam logic [POSITION_BITS-1:0] COUNT_LIMIT = {POSITION_BITS{1'b1}};

    localparam logic [7:0] CH_ANY    = 8'h3F; // '?'
    localparam logic [7:0] CH_DIGIT  = 8'h23; // '#'
    localparam logic [7:0] CH_LETTER = 8'h24; // '$'
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;

    typedef logic [7:0] pbyte_t;
    typedef logic [PATTERN_MAX-1:0][7:0] pattern_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_index_t;

    function automatic logic byte_ok(input pbyte_t p, input pbyte_t d);
        logic r;
        if (p == CH_ANY) begin
            r = 1'b1;
        end else if (p == CH_DIGIT) begin
            r = (d >= CH_0) && (d <= CH_9);
        end else if (p == CH_LETTER) begin
            r = ((d >= CH_LA) && (d <= CH_LZ)) || ((d >= CH_UA) && (d <= CH_UZ));
        end else begin
            r = (p == d);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/wps_align.sv
// lines up the pattern bytes with the window cells for the current length
module wps_align (
    input  logic [wps_pkg::CFG_DATA_W-1:0] pattern_low,
    input  logic [wps_pkg::CFG_DATA_W-1:0] pattern_high,
    input  logic [wps_pkg::CFG_LEN_W-1:0]  pattern_length,
    output wps_pkg::pattern_t              aligned,
    output logic [wps_pkg::LEN_BITS-1:0]   eff_len
);

    wps_pkg::pattern_t pbytes;

    always_comb begin
        for (int k = 0; k < wps_pkg::PATTERN_MAX; k++) begin
            if (k < 8) begin
                pbytes[k] = pattern_low[8*k +: 8];
            end else if (k < 16) begin
                pbytes[k] = pattern_high[8*(k-8) +: 8];
            end else begin
                pbytes[k] = 8'h00;
            end
        end
    end

    always_comb begin
        int n;
        n = int'(pattern_length);
        if (n == 0) begin
            n = 1;
        end
        if (n > wps_pkg::PATTERN_MAX) begin
            n = wps_pkg::PATTERN_MAX;
        end
        eff_len = wps_pkg::LEN_BITS'(n);
        // cell j sees the byte that pattern byte len-1-j must match
        for (int j = 0; j < wps_pkg::PATTERN_MAX; j++) begin
            aligned[j] = wps_pkg::CH_ANY;
            for (int k = 0; k < wps_pkg::PATTERN_MAX; k++) begin
                if ((j < n) && ((n - 1 - j) == k)) begin
                    aligned[j] = pbytes[k];
                end
            end
        end
    end

endmodule

// File: rtl/core/wps_cell.sv
// one window cell: holds a byte, checks it against its pattern byte, passes it on
module wps_cell (
    input  logic            aclk,
    input  logic            shift_en,
    input  wps_pkg::pbyte_t byte_in,
    input  wps_pkg::pbyte_t pat_byte,
    input  logic            ok_in,
    output wps_pkg::pbyte_t byte_out,
    output logic            ok_out
);

    wps_pkg::pbyte_t byte_reg;
    wps_pkg::pbyte_t byte_next;

    // compare against the byte entering, i.e. the window after this shift
    assign ok_out    = ok_in & wps_pkg::byte_ok(pat_byte, byte_in);
    assign byte_next = shift_en ? byte_in : byte_reg;
    assign byte_out  = byte_reg;

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

endmodule

// File: rtl/core/wildcard_pattern_search.sv
// top level: wildcard byte pattern search over a byte stream
// Takes one byte per clock on the s_ stream and reports the start offset of the first place
// where the configured pattern (up to 16 bytes; '?' any byte, '#' digit, '$' letter) matches.
// Each accepted byte is checked in the same cycle by a row of window cells, one per pattern
// byte, and any result appears on m_ in the next cycle from an output register, so the
// sustained rate is one byte per cycle; input stalls only while that register holds a result
// that m_tready has not taken. A buffer gives exactly one result: found with its offset, or
// not found (position zero) at its tlast byte; after a hit the rest of the buffer is dropped.
// Offsets past the 24-bit counter limit are not tested. Write the pattern registers only while
// no byte is in flight.
module wildcard_pattern_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [wps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wps_pkg::S_TDATA_W-1:0]       s_tdata,  // [7:0] data_byte
    input  logic                                s_tlast,  // last
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wps_pkg::M_TDATA_W-1:0]       m_tdata   // [0] found, [24:1] position
);

    localparam int PB = wps_pkg::POSITION_BITS;
    localparam int PM = wps_pkg::PATTERN_MAX;

    logic [wps_pkg::CFG_DATA_W-1:0] pat_low_reg;
    logic [wps_pkg::CFG_DATA_W-1:0] pat_high_reg;
    logic [wps_pkg::CFG_LEN_W-1:0]  pat_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= wps_pkg::CFG_LEN_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                wps_pkg::CFG_PATTERN_LOW:    pat_low_reg  <= cfg_wdata;
                wps_pkg::CFG_PATTERN_HIGH:   pat_high_reg <= cfg_wdata;
                wps_pkg::CFG_PATTERN_LENGTH: pat_len_reg  <= cfg_wdata[wps_pkg::CFG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    wps_pkg::pattern_t              aligned;
    logic [wps_pkg::LEN_BITS-1:0]   eff_len;

    wps_align u_align (
        .pattern_low    (pat_low_reg),
        .pattern_high   (pat_high_reg),
        .pattern_length (pat_len_reg),
        .aligned        (aligned),
        .eff_len        (eff_len)
    );

    logic            matched_reg, matched_next;
    logic [PB-1:0]   count_reg, count_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_found_reg, out_found_next;
    logic [PB-1:0]   out_pos_reg, out_pos_next;

    logic s_acc;
    logic shift_en;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign shift_en = s_acc && !matched_reg;

    wps_pkg::pbyte_t win [PM];
    logic            ok_chain [PM+1];

    assign win[0]      = s_tdata[7:0];
    assign ok_chain[0] = 1'b1;

    for (genvar j = 0; j < PM; j++) begin : g_cell
        if (j < PM - 1) begin : g_mid
            wps_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .byte_in  (win[j]),
                .pat_byte (aligned[j]),
                .ok_in    (ok_chain[j]),
                .byte_out (win[j+1]),
                .ok_out   (ok_chain[j+1])
            );
        end else begin : g_end
            wps_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .byte_in  (win[j]),
                .pat_byte (aligned[j]),
                .ok_in    (ok_chain[j]),
                .byte_out (),
                .ok_out   (ok_chain[j+1])
            );
        end
    end

    logic [PB:0]   count_inc;
    logic          full_window;
    logic          hit;
    logic [PB-1:0] start_pos;

    assign count_inc   = {1'b0, count_reg} + (PB+1)'(1);
    assign full_window = count_inc >= (PB+1)'(eff_len);
    assign hit         = (count_reg != wps_pkg::COUNT_LIMIT) && full_window && ok_chain[PM];
    assign start_pos   = PB'(count_inc - (PB+1)'(eff_len));

    always_comb begin
        matched_next   = matched_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        if (s_acc) begin
            if (matched_reg) begin
                // drop bytes until the end of the buffer
                if (s_tlast) begin
                    matched_next = 1'b0;
                    count_next   = '0;
                end
            end else begin
                if (count_reg != wps_pkg::COUNT_LIMIT) begin
                    count_next = count_inc[PB-1:0];
                end
                if (hit) begin
                    out_valid_next = 1'b1;
                    out_found_next = 1'b1;
                    out_pos_next   = start_pos;
                    if (s_tlast) begin
                        count_next = '0;
                    end else begin
                        matched_next = 1'b1;
                    end
                end else if (s_tlast) begin
                    out_valid_next = 1'b1;
                    out_found_next = 1'b0;
                    out_pos_next   = '0;
                    count_next     = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matched_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            matched_reg   <= matched_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = wps_pkg::M_TDATA_W'({out_pos_reg, out_found_reg});

`ifndef SYNTHESIS
    a_notfound_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_found_reg) |-> (out_pos_reg == '0))
        else $error("not-found result carries a nonzero position");

    a_drop_after_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && matched_reg) |=> !out_valid_reg)
        else $error("result produced for a byte after a hit");

    a_matched_count: assert property (@(posedge aclk) disable iff (!aresetn)
        matched_reg |-> (count_reg != '0))
        else $error("hit recorded with an empty byte count");
`endif

endmodule
